### hdl/mbds_pkg.sv
// Shared types and constants for the multiplexed BCD display scanner.
`default_nettype none

package mbds_pkg;

  // Command codes carried by each request; codes above tick act as off.
  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_OFF    = 3'd1,
    CMD_ON     = 3'd2,
    CMD_NEWVAL = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_t;

  localparam int DIGIT_WIDTH = 4;
  // The converter always keeps five decimal digits.
  localparam int CONV_DIGITS = 5;
  localparam int BCD_WIDTH   = CONV_DIGITS * DIGIT_WIDTH;
  // The scan visits at most four positions.
  localparam int MAX_SCAN    = 4;
  localparam int POS_WIDTH   = 2;

  // Request handed to the scan stage.
  typedef struct packed {
    cmd_t                   cmd;
    logic [BCD_WIDTH-1:0]   bcd;
  } scan_req_t;

  // What the display drives after one request.
  typedef struct packed {
    logic                   lit;
    logic [POS_WIDTH-1:0]   anode_select;
    logic [DIGIT_WIDTH-1:0] shown_digit;
  } scan_res_t;

endpackage

`default_nettype wire

### hdl/mbds_dabble.sv
// A slice of shift-and-add-3 binary to BCD conversion steps.
`default_nettype none

module mbds_dabble #(
  parameter int BIN_WIDTH  = 16,
  parameter int FIRST_STEP = 0,
  parameter int NUM_STEPS  = 8
) (
  input  wire logic [BIN_WIDTH-1:0]          bin_value,
  input  wire logic [mbds_pkg::BCD_WIDTH-1:0] bcd_in,
  output logic      [mbds_pkg::BCD_WIDTH-1:0] bcd_out
);

  // Each step adds 3 to every digit of 5 or more, then shifts in the next bit.
  always_comb begin
    logic [mbds_pkg::BCD_WIDTH-1:0]   acc;
    logic [mbds_pkg::DIGIT_WIDTH-1:0] nib;
    acc = bcd_in;
    for (int i = 0; i < NUM_STEPS; i++) begin
      for (int d = 0; d < mbds_pkg::CONV_DIGITS; d++) begin
        nib = acc[d*mbds_pkg::DIGIT_WIDTH +: mbds_pkg::DIGIT_WIDTH];
        if (nib >= 4'd5) begin
          acc[d*mbds_pkg::DIGIT_WIDTH +: mbds_pkg::DIGIT_WIDTH] = nib + 4'd3;
        end
      end
      acc = {acc[mbds_pkg::BCD_WIDTH-2:0], bin_value[BIN_WIDTH-1-(FIRST_STEP+i)]};
    end
    bcd_out = acc;
  end

endmodule

`default_nettype wire

### hdl/mbds_scan.sv
// Digit store, scan position and latched digit, with the result register.
`default_nettype none

module mbds_scan #(
  parameter int NUM_DIGITS = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                upd_en,
  input  wire mbds_pkg::scan_req_t req,
  output mbds_pkg::scan_res_t      res_r
);

  localparam int SCAN_COUNT = (NUM_DIGITS < mbds_pkg::MAX_SCAN) ? NUM_DIGITS
                                                                : mbds_pkg::MAX_SCAN;

  logic [mbds_pkg::DIGIT_WIDTH-1:0] digits_r   [mbds_pkg::MAX_SCAN];
  logic [mbds_pkg::DIGIT_WIDTH-1:0] digits_nxt [mbds_pkg::MAX_SCAN];
  logic [mbds_pkg::DIGIT_WIDTH-1:0] new_digits [mbds_pkg::MAX_SCAN];
  logic [mbds_pkg::POS_WIDTH-1:0]   pos_r, pos_nxt, pos_tick;
  logic [mbds_pkg::POS_WIDTH:0]     pos_inc;
  logic                             off_r, off_nxt;
  logic [mbds_pkg::DIGIT_WIDTH-1:0] latched_r, latched_nxt;
  mbds_pkg::scan_res_t              res_nxt;

  // Digits taken from the converted value; positions beyond the scan stay zero.
  always_comb begin
    for (int d = 0; d < mbds_pkg::MAX_SCAN; d++) begin
      if (d < SCAN_COUNT) begin
        new_digits[d] = req.bcd[d*mbds_pkg::DIGIT_WIDTH +: mbds_pkg::DIGIT_WIDTH];
      end else begin
        new_digits[d] = '0;
      end
    end
  end

  // Next scan position on a tick, wrapping back to the ones digit.
  assign pos_inc  = {1'b0, pos_r} + 3'd1;
  assign pos_tick = (pos_inc >= 3'(SCAN_COUNT)) ? '0 : pos_inc[mbds_pkg::POS_WIDTH-1:0];

  // Command decode and state update.
  always_comb begin
    digits_nxt  = digits_r;
    pos_nxt     = pos_r;
    off_nxt     = off_r;
    latched_nxt = latched_r;
    case (req.cmd)
      mbds_pkg::CMD_INIT: begin
        for (int d = 0; d < mbds_pkg::MAX_SCAN; d++) begin
          digits_nxt[d] = '0;
        end
        off_nxt     = 1'b0;
        pos_nxt     = '0;
        latched_nxt = '0;
      end
      mbds_pkg::CMD_ON: begin
        if (off_r) begin
          off_nxt     = 1'b0;
          pos_nxt     = '0;
          latched_nxt = digits_r[0];
        end
      end
      mbds_pkg::CMD_NEWVAL: begin
        digits_nxt = new_digits;
      end
      mbds_pkg::CMD_TICK: begin
        if (!off_r) begin
          pos_nxt     = pos_tick;
          latched_nxt = digits_r[pos_tick];
        end
      end
      default: begin
        off_nxt = 1'b1;
        pos_nxt = '0;
      end
    endcase
  end

  // Result fields are zero while the display is blanked.
  always_comb begin
    res_nxt.lit          = !off_nxt;
    res_nxt.anode_select = off_nxt ? '0 : pos_nxt;
    res_nxt.shown_digit  = off_nxt ? '0 : latched_nxt;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < mbds_pkg::MAX_SCAN; d++) begin
        digits_r[d] <= '0;
      end
      pos_r     <= '0;
      off_r     <= 1'b0;
      latched_r <= '0;
    end else if (upd_en) begin
      digits_r  <= digits_nxt;
      pos_r     <= pos_nxt;
      off_r     <= off_nxt;
      latched_r <= latched_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (upd_en) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/multiplexed_bcd_display_scanner.sv
// Top level of the multiplexed BCD display scanner.
//
// Each input request carries a command and a binary value; each produces
// exactly one result request giving the lit flag, the anode position and
// the digit shown. Both channels use valid and stall: a request moves on a
// rising edge where valid is high and stall is low.
// A request passes through two register stages, the input register and
// the result register. Throughput is one request per cycle while the
// receiver does not stall: the first half of the BCD conversion runs ahead of the
// input register, the second half and the scan update run between the
// input register and the result register.
// When the receiver stalls, the result register holds, then the input
// register fills and in_stall rises; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties both stages, clears the stored
// digits to zero, puts the scan on the ones digit and leaves it lit.
`default_nettype none

module multiplexed_bcd_display_scanner #(
  parameter int BIN_WIDTH  = 16,
  parameter int NUM_DIGITS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_command,
  input  wire logic [15:0] in_bin_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_lit,
  output logic [1:0]       out_anode_select,
  output logic [3:0]       out_shown_digit
);

  localparam int HALF_STEPS = BIN_WIDTH / 2;
  localparam int REST_STEPS = BIN_WIDTH - HALF_STEPS;

  logic                           s1_valid_r;
  mbds_pkg::cmd_t                 s1_cmd_r;
  logic [BIN_WIDTH-1:0]           s1_val_r;
  logic [mbds_pkg::BCD_WIDTH-1:0] s1_bcd_r;
  logic [mbds_pkg::BCD_WIDTH-1:0] bcd_mid, bcd_full;
  logic                           out_valid_r;
  logic                           move, s1_en;
  mbds_pkg::scan_req_t            req;
  mbds_pkg::scan_res_t            res_r;

  // Handshake: the result register frees up when empty or taken.
  assign move     = !out_valid_r || !out_stall;
  assign s1_en    = move || !s1_valid_r;
  assign in_stall = !s1_en;

  // First half of the conversion on the incoming value.
  mbds_dabble #(
    .BIN_WIDTH  (BIN_WIDTH),
    .FIRST_STEP (0),
    .NUM_STEPS  (HALF_STEPS)
  ) u_dabble_hi (
    .bin_value (in_bin_value[BIN_WIDTH-1:0]),
    .bcd_in    ('0),
    .bcd_out   (bcd_mid)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_cmd_r <= mbds_pkg::cmd_t'(in_command);
      s1_val_r <= in_bin_value[BIN_WIDTH-1:0];
      s1_bcd_r <= bcd_mid;
    end
  end

  // Second half of the conversion.
  mbds_dabble #(
    .BIN_WIDTH  (BIN_WIDTH),
    .FIRST_STEP (HALF_STEPS),
    .NUM_STEPS  (REST_STEPS)
  ) u_dabble_lo (
    .bin_value (s1_val_r),
    .bcd_in    (s1_bcd_r),
    .bcd_out   (bcd_full)
  );

  assign req.cmd = s1_cmd_r;
  assign req.bcd = bcd_full;

  // Scan state and result register.
  mbds_scan #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (s1_valid_r && move),
    .req    (req),
    .res_r  (res_r)
  );

  // Result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= s1_valid_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_lit          = res_r.lit;
  assign out_anode_select = res_r.anode_select;
  assign out_shown_digit  = res_r.shown_digit;

endmodule

`default_nettype wire

### dv/display_scan_checker.sv
// Checker that predicts and compares every result of the display scanner.
`default_nettype none

module display_scan_checker #(
  parameter int BIN_WIDTH  = 16,
  parameter int NUM_DIGITS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [2:0]  in_command,
  input  wire logic [15:0] in_bin_value,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        out_lit,
  input  wire logic [1:0]  out_anode_select,
  input  wire logic [3:0]  out_shown_digit,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // The scan never visits more positions than there are stored digits.
  localparam int SCAN_LEN = (NUM_DIGITS < mbds_pkg::MAX_SCAN) ? NUM_DIGITS
                                                              : mbds_pkg::MAX_SCAN;

  // Predicted display state.
  logic [mbds_pkg::DIGIT_WIDTH-1:0] digits [NUM_DIGITS];
  logic [mbds_pkg::POS_WIDTH-1:0]   scan_pos;
  logic                             blanked;
  logic [mbds_pkg::DIGIT_WIDTH-1:0] latched;

  // Results predicted but not yet seen on the output channel.
  mbds_pkg::scan_res_t shown_q[$];

  int fail_count = 0;
  int outstanding = 0;

  assign errors  = fail_count;
  assign pending = outstanding;

  // Shift-and-add-3 conversion over the low BIN_WIDTH bits into five digits.
  function automatic logic [mbds_pkg::BCD_WIDTH-1:0] bin_to_bcd(input logic [15:0] bin);
    logic [mbds_pkg::BCD_WIDTH-1:0] acc;
    acc = '0;
    for (int i = 0; i < BIN_WIDTH; i++) begin
      for (int d = 0; d < mbds_pkg::CONV_DIGITS; d++) begin
        if (acc[mbds_pkg::DIGIT_WIDTH*d +: mbds_pkg::DIGIT_WIDTH] >= 4'd5) begin
          acc[mbds_pkg::DIGIT_WIDTH*d +: mbds_pkg::DIGIT_WIDTH] =
            acc[mbds_pkg::DIGIT_WIDTH*d +: mbds_pkg::DIGIT_WIDTH] + 4'd3;
        end
      end
      acc = {acc[mbds_pkg::BCD_WIDTH-2:0], bin[BIN_WIDTH-1-i]};
    end
    return acc;
  endfunction

  // Keep only the low digits of the converted value.
  task automatic store_digits(input logic [15:0] bin);
    logic [mbds_pkg::BCD_WIDTH-1:0] bcd;
    bcd = bin_to_bcd(bin);
    for (int d = 0; d < NUM_DIGITS; d++) begin
      digits[d] = bcd[mbds_pkg::DIGIT_WIDTH*d +: mbds_pkg::DIGIT_WIDTH];
    end
  endtask

  // Entering a position latches its digit onto the segments.
  task automatic enter_pos(input int pos);
    scan_pos = pos[mbds_pkg::POS_WIDTH-1:0];
    latched  = (pos < NUM_DIGITS) ? digits[pos] : '0;
  endtask

  // Apply one request to the predicted state and return what the display drives.
  task automatic step_display(input logic [2:0] cmd, input logic [15:0] bin,
                              output mbds_pkg::scan_res_t res);
    int nxt;
    case (cmd)
      mbds_pkg::CMD_INIT: begin
        store_digits('0);
        blanked = 1'b0;
        enter_pos(0);
      end
      mbds_pkg::CMD_ON: begin
        if (blanked) begin
          blanked = 1'b0;
          enter_pos(0);
        end
      end
      mbds_pkg::CMD_NEWVAL: begin
        store_digits(bin);
      end
      mbds_pkg::CMD_TICK: begin
        if (!blanked) begin
          nxt = int'(scan_pos) + 1;
          if (nxt >= SCAN_LEN) nxt = 0;
          enter_pos(nxt);
        end
      end
      // Off, and every code above tick, blanks and rewinds to ones.
      default: begin
        blanked  = 1'b1;
        scan_pos = '0;
      end
    endcase
    if (blanked) begin
      res = '0;
    end else begin
      res = '{lit: 1'b1, anode_select: scan_pos, shown_digit: latched};
    end
  endtask

  // Report one field that differs from its prediction.
  task automatic check_field(input string name, input logic [3:0] want,
                             input logic [3:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Compare results first, then predict the request taken at the same edge.
  always @(posedge clk) begin
    mbds_pkg::scan_res_t want;
    mbds_pkg::scan_res_t got;
    if (!rst_n) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        digits[d] = '0;
      end
      scan_pos = '0;
      blanked  = 1'b0;
      latched  = '0;
      shown_q.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{lit: out_lit, anode_select: out_anode_select,
                shown_digit: out_shown_digit};
        if (shown_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected, got lit %0b anode %0d digit %0d",
                   $time, got.lit, got.anode_select, got.shown_digit);
        end else begin
          want = shown_q.pop_front();
          check_field("lit", 4'(want.lit), 4'(got.lit));
          check_field("anode_select", 4'(want.anode_select), 4'(got.anode_select));
          check_field("shown_digit", want.shown_digit, got.shown_digit);
        end
      end
      if (in_valid && !in_stall) begin
        step_display(in_command, in_bin_value, want);
        shown_q.push_back(want);
      end
      outstanding <= shown_q.size();
    end
  end

endmodule

`default_nettype wire

### dv/tb.sv
// Testbench top: drives requests into the display scanner and gives the verdict.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 10;
  // Highest command code; everything above tick acts as off.
  localparam logic [2:0] CMD_ALIAS_HI = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_command;
  logic [15:0] in_bin_value;
  logic        out_valid;
  logic        out_stall;
  logic        out_lit;
  logic [1:0]  out_anode_select;
  logic [3:0]  out_shown_digit;
  int          errors;
  int          pending;
  int          cycles = 0;
  bit          steady_in = 1'b0;

  multiplexed_bcd_display_scanner DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_bin_value     (in_bin_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_lit          (out_lit),
    .out_anode_select (out_anode_select),
    .out_shown_digit  (out_shown_digit)
  );

  display_scan_checker scan_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_bin_value     (in_bin_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_lit          (out_lit),
    .out_anode_select (out_anode_select),
    .out_shown_digit  (out_shown_digit),
    .errors           (errors),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Values lean toward the extremes and toward numbers with few digits.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1: return 16'($urandom_range(0, 99));
      2: return 16'($urandom_range(0, 9999));
      default: return 16'($urandom);
    endcase
  endfunction

  // Ticks and new values dominate so that the scan gets walked often.
  function automatic logic [2:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return mbds_pkg::CMD_TICK;
    if (r < 65) return mbds_pkg::CMD_NEWVAL;
    if (r < 77) return mbds_pkg::CMD_ON;
    if (r < 87) return mbds_pkg::CMD_OFF;
    if (r < 92) return mbds_pkg::CMD_INIT;
    return 3'($urandom_range(int'(mbds_pkg::CMD_TICK) + 1, int'(CMD_ALIAS_HI)));
  endfunction

  // Offer one request, with an optional idle gap first, and wait until it is taken.
  task automatic send(input logic [2:0] cmd, input logic [15:0] bin);
    int gap;
    gap = 0;
    if (!steady_in && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_bin_value <= bin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Receiver stalls in short bursts, with long free-running stretches between some.
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(40, 150)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_stall <= 1'b1;
      repeat (pick_gap()) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stimulus: directed sequence, then random traffic, then drain and verdict.
  initial begin
    int sent;
    int sweep;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_command   <= mbds_pkg::CMD_INIT;
    in_bin_value <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Largest value: the ten-thousands digit is dropped and ones stays latched.
    send(mbds_pkg::CMD_NEWVAL, 16'hFFFF);
    repeat (4) send(mbds_pkg::CMD_TICK, 16'h0000);
    // New value mid-scan shows up only at the next position change.
    send(mbds_pkg::CMD_NEWVAL, 16'd9999);
    send(mbds_pkg::CMD_TICK, 16'hFFFF);
    // Off twice, tick and new value while blanked, then on twice.
    send(mbds_pkg::CMD_OFF, 16'hFFFF);
    send(mbds_pkg::CMD_OFF, 16'h0000);
    send(mbds_pkg::CMD_TICK, 16'h0000);
    send(mbds_pkg::CMD_NEWVAL, 16'd1234);
    send(mbds_pkg::CMD_ON, 16'h0000);
    send(mbds_pkg::CMD_ON, 16'hFFFF);
    send(mbds_pkg::CMD_TICK, 16'h0000);
    // Codes above tick must blank exactly like off.
    for (int c = int'(mbds_pkg::CMD_TICK) + 1; c <= int'(CMD_ALIAS_HI); c++) begin
      send(3'(c), 16'hFFFF);
      send(mbds_pkg::CMD_ON, 16'h0000);
    end
    // Init while scanning and while blanked; a value whose low digits are all zero.
    send(mbds_pkg::CMD_INIT, 16'hFFFF);
    send(mbds_pkg::CMD_NEWVAL, 16'd10000);
    send(mbds_pkg::CMD_TICK, 16'h0000);
    send(mbds_pkg::CMD_OFF, 16'h0000);
    send(mbds_pkg::CMD_INIT, 16'h0000);

    // Random part: full scan sweeps after a new value, mixed with loose commands.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 200 == 0) steady_in = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 3) begin
        send(mbds_pkg::CMD_NEWVAL, pick_value());
        sweep = $urandom_range(3, 6);
        repeat (sweep) send(mbds_pkg::CMD_TICK, 16'($urandom));
        sent += sweep + 1;
      end else begin
        send(pick_cmd(), pick_value());
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Wait for every predicted result, then a few more cycles for strays.
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
